@@ sv/bsmc_pkg.sv @@
`default_nettype none
package bsmc_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned HASH_W = 32;

  localparam logic [HASH_W-1:0] START_MASK = 32'hA5A5_A5A5;
  localparam logic [HASH_W-1:0] BYTE_BIAS  = 32'h0000_009E;
  localparam logic [HASH_W-1:0] MIX_MULT   = 32'h045D_9F3B;
  localparam int unsigned       MIX_ROT    = 7;

  // One message byte as held in the input register
  typedef struct packed {
    logic              last_byte;
    logic [DATA_W-1:0] data_byte;
  } item_t;

  // Handshake between the input register and the output side
  typedef struct packed {
    logic valid;
    logic last;
  } stage_stat_t;

endpackage : bsmc_pkg
`default_nettype wire

@@ sv/bsmc_in_stage.sv @@
`default_nettype none
module bsmc_in_stage (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  bsmc_pkg::item_t in_item,
  input  wire                  out_free,
  output bsmc_pkg::item_t      item_q,
  output bsmc_pkg::stage_stat_t stat,
  output logic                 advance
);
  import bsmc_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // A non-last item never needs the output; a last one needs a free result slot
  assign advance   = valid_r && (!item_r.last_byte || out_free);
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_q     = item_r;
  assign stat.valid = valid_r;
  assign stat.last  = item_r.last_byte;

endmodule : bsmc_in_stage
`default_nettype wire

@@ sv/bsmc_mix_core.sv @@
`default_nettype none
module bsmc_mix_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  [bsmc_pkg::HASH_W-1:0] seed,
  input  wire  bsmc_pkg::item_t       item,
  input  wire                         consume,
  output logic [bsmc_pkg::HASH_W-1:0] checksum
);
  import bsmc_pkg::*;

  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_nxt;
  logic [HASH_W-1:0] idx_r;
  logic [HASH_W-1:0] idx_nxt;
  logic              in_msg_r;
  logic              in_msg_nxt;

  logic [HASH_W-1:0] hash_base;
  logic [HASH_W-1:0] idx_base;
  logic [HASH_W-1:0] term;
  logic [HASH_W-1:0] mixed;
  logic [HASH_W-1:0] rotated;

  // Reload from the seed on the first byte of a message
  assign hash_base = in_msg_r ? hash_r : (seed ^ START_MASK);
  assign idx_base  = in_msg_r ? idx_r  : '0;

  assign term     = {{(HASH_W-DATA_W){1'b0}}, item.data_byte} + BYTE_BIAS + idx_base;
  assign mixed    = hash_base ^ term;
  assign rotated  = {mixed[HASH_W-1-MIX_ROT:0], mixed[HASH_W-1:HASH_W-MIX_ROT]};
  assign hash_nxt = rotated * MIX_MULT;
  assign idx_nxt  = idx_base + HASH_W'(1);
  assign in_msg_nxt = !item.last_byte;

  assign checksum = hash_nxt ^ idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= '0;
      idx_r    <= '0;
      in_msg_r <= 1'b0;
    end else if (consume) begin
      hash_r   <= hash_nxt;
      idx_r    <= idx_nxt;
      in_msg_r <= in_msg_nxt;
    end
  end

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    consume && item.last_byte |=> !in_msg_r)
    else $error("message still open after its last byte");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !consume |=> $stable(hash_r) && $stable(idx_r) && $stable(in_msg_r))
    else $error("mix state moved without a byte");

  a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
    consume && !in_msg_r |=> idx_r == HASH_W'(1))
    else $error("first byte of a message did not restart the count");

endmodule : bsmc_mix_core
`default_nettype wire

@@ sv/byte_stream_mix_checksum_unit.sv @@
`default_nettype none
// Byte-stream mixing checksum. Bytes arrive on the in_ stream one per item,
// in_tlast marking the final byte of a message; each message yields one
// 32-bit checksum item on the out_ stream, presented in the cycle after its
// last byte leaves the input register. The block sustains one byte per
// cycle, but a message's last byte waits while an earlier checksum is
// untaken. Every byte passes an input register, two adds, an XOR, a fixed
// rotate and one 32x32 constant multiply that feed the running-hash
// register, and a checksum lands in an output register that lets the next
// message's bytes keep flowing while it waits to be taken. The seed is
// written on the cfg_ channel (always ready) and is sampled at the first
// byte of each message; write it only between messages.
module byte_stream_mix_checksum_unit (
  input  wire         clk,
  input  wire         rst_n,
  // configuration: seed
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_data,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata   // [31:0] checksum
);
  import bsmc_pkg::*;

  logic [HASH_W-1:0] seed_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [HASH_W-1:0] out_data_r;

  item_t             in_item;
  item_t             item_q;
  stage_stat_t       stat;
  logic              advance;
  logic              out_free;
  logic [HASH_W-1:0] checksum;

  // Seed register: writes always land at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid) begin
      seed_r <= cfg_data;
    end
  end

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  // The result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_tready;

  bsmc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_item  (in_item),
    .out_free (out_free),
    .item_q   (item_q),
    .stat     (stat),
    .advance  (advance)
  );

  bsmc_mix_core u_mix_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .seed    (seed_r),
    .item    (item_q),
    .consume (advance),
    .checksum(checksum)
  );

  // Output register: load on a finished message, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && stat.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stat.last) begin
      out_data_r <= checksum;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && stat.last))
    else $error("checksum appeared without a last byte");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.valid && !advance |-> stat.last && out_valid_r && !out_tready)
    else $error("input register stalled with room downstream");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(advance && stat.last))
    else $error("pending checksum overwritten");

endmodule : byte_stream_mix_checksum_unit
`default_nettype wire
